FILE: sv/dam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dam_pkg;

  // Address width limits
  localparam int unsigned ADDR_WIDTH_DEF = 32;
  localparam int unsigned PHYS_W         = 32;

  // Configuration register indexes
  localparam logic [2:0] REG_MAP_MODE  = 3'd0;
  localparam logic [2:0] REG_CHAN_BITS = 3'd1;
  localparam logic [2:0] REG_RANK_BITS = 3'd2;
  localparam logic [2:0] REG_BANK_BITS = 3'd3;
  localparam logic [2:0] REG_ROW_BITS  = 3'd4;
  localparam logic [2:0] REG_COL_BITS  = 3'd5;
  localparam logic [2:0] REG_CSZ_BITS  = 3'd6;
  localparam logic [2:0] REG_LINE_BITS = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  // Mapping schemes
  localparam logic [2:0] MODE_CHAN_COL = 3'd0;
  localparam logic [2:0] MODE_OPEN     = 3'd1;
  localparam logic [2:0] MODE_SDRAM    = 3'd2;
  localparam logic [2:0] MODE_FIXED    = 3'd3;
  localparam logic [2:0] MODE_CLOSE    = 3'd4;

  // Fixed chipset map
  localparam logic [6:0] FIX_COL_OFF  = 7'd3;
  localparam logic [4:0] FIX_COL_WID  = 5'd10;
  localparam logic [6:0] FIX_BANK_OFF = 7'd13;
  localparam logic [4:0] FIX_BANK_WID = 5'd2;
  localparam logic [6:0] FIX_RANK_OFF = 7'd28;
  localparam logic [4:0] FIX_RANK_WID = 5'd2;
  localparam logic [6:0] FIX_TOP_OFF  = 7'd30;
  localparam logic [4:0] FULL_WID     = 5'd31;

  // Result widths
  localparam int unsigned CHAN_W = 4;
  localparam int unsigned RANK_W = 4;
  localparam int unsigned BANK_W = 5;
  localparam int unsigned ROW_W  = 20;
  localparam int unsigned COL_W  = 16;

  typedef struct packed {
    logic [2:0] map_mode;
    logic [2:0] chan_bits;
    logic [2:0] rank_bits;
    logic [2:0] bank_bits;
    logic [4:0] row_bits;
    logic [4:0] col_bits;
    logic [2:0] col_size_bits;
    logic [3:0] line_bits;
  } cfg_t;

  // One field: absolute bit offset into the address and its width
  typedef struct packed {
    logic [6:0] off;
    logic [4:0] wid;
  } fld_t;

  // Field placement worked out for one item
  typedef struct packed {
    logic       known;
    logic       fixed;
    fld_t       chan;
    fld_t       rank;
    fld_t       bank;
    fld_t       row;
    fld_t       lo;
    fld_t       hi;
    logic [3:0] lo_sh;
    logic [6:0] total;
  } lay_t;

  // Shifted fields, not yet masked
  typedef struct packed {
    logic              known;
    logic [CHAN_W-1:0] chan;
    logic [4:0]        chan_w;
    logic [RANK_W-1:0] rank;
    logic [4:0]        rank_w;
    logic [BANK_W-1:0] bank;
    logic [4:0]        bank_w;
    logic [ROW_W-1:0]  row;
    logic [4:0]        row_w;
    logic [COL_W-1:0]  lo;
    logic [4:0]        lo_w;
    logic [COL_W-1:0]  hi;
    logic [4:0]        hi_w;
    logic [3:0]        lo_sh;
    logic              oor;
  } shf_t;

  // Low mask of w ones, saturating at the widest result field
  function automatic logic [ROW_W-1:0] low_mask(logic [4:0] w);
    logic [ROW_W-1:0] m;
    if (w >= 5'(ROW_W)) begin
      m = '1;
    end else begin
      m = (ROW_W'(1) << w) - ROW_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dam_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module dam_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [dam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dam_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dam_pkg::cfg_t                       cfg
);

  dam_pkg::cfg_t cfg_r;
  dam_pkg::cfg_t cfg_nxt;

  // Decode the register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        dam_pkg::REG_MAP_MODE:  cfg_nxt.map_mode      = cfg_wdata[2:0];
        dam_pkg::REG_CHAN_BITS: cfg_nxt.chan_bits     = cfg_wdata[2:0];
        dam_pkg::REG_RANK_BITS: cfg_nxt.rank_bits     = cfg_wdata[2:0];
        dam_pkg::REG_BANK_BITS: cfg_nxt.bank_bits     = cfg_wdata[2:0];
        dam_pkg::REG_ROW_BITS:  cfg_nxt.row_bits      = cfg_wdata[4:0];
        dam_pkg::REG_COL_BITS:  cfg_nxt.col_bits      = cfg_wdata[4:0];
        dam_pkg::REG_CSZ_BITS:  cfg_nxt.col_size_bits = cfg_wdata[2:0];
        dam_pkg::REG_LINE_BITS: cfg_nxt.line_bits     = cfg_wdata[3:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers, load reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_mode      <= dam_pkg::MODE_OPEN;
      cfg_r.chan_bits     <= 3'd0;
      cfg_r.rank_bits     <= 3'd2;
      cfg_r.bank_bits     <= 3'd2;
      cfg_r.row_bits      <= 5'd13;
      cfg_r.col_bits      <= 5'd10;
      cfg_r.col_size_bits <= 3'd3;
      cfg_r.line_bits     <= 4'd6;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/dam_plan.sv
`timescale 1ns / 1ps
`default_nettype none

module dam_plan #(
  parameter int unsigned ADDR_W = dam_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dam_pkg::cfg_t               cfg,
  input  wire logic                        up_valid,
  input  wire logic [dam_pkg::PHYS_W-1:0]  up_addr,
  output logic                             up_ready,
  input  wire logic                        dn_ready,
  output logic                             dn_valid,
  output logic [ADDR_W-1:0]                dn_addr,
  output dam_pkg::lay_t                    dn_lay
);

  logic               v_r;
  logic [ADDR_W-1:0]  addr_r;
  dam_pkg::lay_t      lay_r;
  dam_pkg::lay_t      lay_nxt;
  logic [3:0]         lo_w;
  logic [4:0]         hi_w;
  logic [4:0]         ch_w;
  logic [4:0]         rk_w;
  logic [4:0]         bk_w;
  logic [6:0]         p;

  // Column low and high widths, saturating at zero
  always_comb begin
    lo_w = (cfg.line_bits > {1'b0, cfg.col_size_bits}) ?
           cfg.line_bits - {1'b0, cfg.col_size_bits} : 4'd0;
    hi_w = (cfg.col_bits > {1'b0, lo_w}) ? cfg.col_bits - {1'b0, lo_w} : 5'd0;
    ch_w = {2'b00, cfg.chan_bits};
    rk_w = {2'b00, cfg.rank_bits};
    bk_w = {2'b00, cfg.bank_bits};
  end

  // Place the fields from the low end, one after another, except in the fixed map
  always_comb begin
    lay_nxt = '0;
    p       = 7'(cfg.col_size_bits);
    unique case (cfg.map_mode)
      dam_pkg::MODE_CHAN_COL: begin
        lay_nxt.known    = 1'b1;
        lay_nxt.chan     = '{off: p, wid: ch_w};   p = p + 7'(ch_w);
        lay_nxt.lo       = '{off: p, wid: cfg.col_bits}; p = p + 7'(cfg.col_bits);
        lay_nxt.rank     = '{off: p, wid: rk_w};   p = p + 7'(rk_w);
        lay_nxt.bank     = '{off: p, wid: bk_w};   p = p + 7'(bk_w);
        lay_nxt.row      = '{off: p, wid: cfg.row_bits}; p = p + 7'(cfg.row_bits);
        lay_nxt.total    = p;
      end
      dam_pkg::MODE_OPEN: begin
        lay_nxt.known    = 1'b1;
        lay_nxt.lo_sh    = lo_w;
        lay_nxt.lo       = '{off: p, wid: 5'(lo_w)}; p = p + 7'(lo_w);
        lay_nxt.chan     = '{off: p, wid: ch_w};   p = p + 7'(ch_w);
        lay_nxt.hi       = '{off: p, wid: hi_w};   p = p + 7'(hi_w);
        lay_nxt.bank     = '{off: p, wid: bk_w};   p = p + 7'(bk_w);
        lay_nxt.rank     = '{off: p, wid: rk_w};   p = p + 7'(rk_w);
        lay_nxt.row      = '{off: p, wid: cfg.row_bits}; p = p + 7'(cfg.row_bits);
        lay_nxt.total    = p;
      end
      dam_pkg::MODE_SDRAM: begin
        lay_nxt.known    = 1'b1;
        lay_nxt.lo_sh    = lo_w;
        lay_nxt.lo       = '{off: p, wid: 5'(lo_w)}; p = p + 7'(lo_w);
        lay_nxt.chan     = '{off: p, wid: ch_w};   p = p + 7'(ch_w);
        lay_nxt.hi       = '{off: p, wid: hi_w};   p = p + 7'(hi_w);
        lay_nxt.bank     = '{off: p, wid: bk_w};   p = p + 7'(bk_w);
        lay_nxt.row      = '{off: p, wid: cfg.row_bits}; p = p + 7'(cfg.row_bits);
        lay_nxt.rank     = '{off: p, wid: rk_w};   p = p + 7'(rk_w);
        lay_nxt.total    = p;
      end
      dam_pkg::MODE_FIXED: begin
        lay_nxt.known    = 1'b1;
        lay_nxt.fixed    = 1'b1;
        lay_nxt.lo       = '{off: dam_pkg::FIX_COL_OFF,  wid: dam_pkg::FIX_COL_WID};
        lay_nxt.bank     = '{off: dam_pkg::FIX_BANK_OFF, wid: dam_pkg::FIX_BANK_WID};
        lay_nxt.rank     = '{off: dam_pkg::FIX_RANK_OFF, wid: dam_pkg::FIX_RANK_WID};
        lay_nxt.row      = '{off: 7'd0, wid: dam_pkg::FULL_WID};
        lay_nxt.total    = dam_pkg::FIX_TOP_OFF;
      end
      dam_pkg::MODE_CLOSE: begin
        lay_nxt.known    = 1'b1;
        lay_nxt.lo_sh    = lo_w;
        lay_nxt.lo       = '{off: p, wid: 5'(lo_w)}; p = p + 7'(lo_w);
        lay_nxt.chan     = '{off: p, wid: ch_w};   p = p + 7'(ch_w);
        lay_nxt.bank     = '{off: p, wid: bk_w};   p = p + 7'(bk_w);
        lay_nxt.rank     = '{off: p, wid: rk_w};   p = p + 7'(rk_w);
        lay_nxt.hi       = '{off: p, wid: hi_w};   p = p + 7'(hi_w);
        lay_nxt.row      = '{off: p, wid: cfg.row_bits}; p = p + 7'(cfg.row_bits);
        lay_nxt.total    = p;
      end
      default: begin
        lay_nxt = '0;
      end
    endcase
  end

  assign up_ready = !v_r || dn_ready;

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  // Load the payload on a transfer
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      addr_r <= up_addr[ADDR_W-1:0];
      lay_r  <= lay_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_addr  = addr_r;
  assign dn_lay   = lay_r;

`ifndef SYNTHESIS
  // The row field never runs past the total that bounds the range check
  a_row_in_total: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && lay_r.known && !lay_r.fixed) |->
      ({1'b0, lay_r.row.off} + 8'(lay_r.row.wid) <= {1'b0, lay_r.total}))
    else $error("row field ends above total offset");
`endif

endmodule

`default_nettype wire

FILE: sv/dam_shift.sv
`timescale 1ns / 1ps
`default_nettype none

module dam_shift #(
  parameter int unsigned ADDR_W = dam_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  input  wire logic [ADDR_W-1:0] up_addr,
  input  wire dam_pkg::lay_t     up_lay,
  output logic                   up_ready,
  input  wire logic              dn_ready,
  output logic                   dn_valid,
  output dam_pkg::shf_t          dn_shf
);

  logic                          v_r;
  dam_pkg::shf_t                 shf_r;
  dam_pkg::shf_t                 shf_nxt;
  logic [dam_pkg::PHYS_W-1:0]    a32;
  logic [dam_pkg::ROW_W-1:0]     fix_row;

  // Fixed chipset row: bit 27 on top, bit 15 below it, a zero bit, then bits 26..16
  always_comb begin
    a32     = dam_pkg::PHYS_W'(up_addr);
    fix_row = dam_pkg::ROW_W'({a32[27], a32[15], 1'b0, a32[26:16]});
  end

  // Bring every field down to bit zero and flag address bits above the total
  always_comb begin
    shf_nxt        = '0;
    shf_nxt.known  = up_lay.known;
    shf_nxt.chan   = dam_pkg::CHAN_W'(up_addr >> up_lay.chan.off);
    shf_nxt.chan_w = up_lay.chan.wid;
    shf_nxt.rank   = dam_pkg::RANK_W'(up_addr >> up_lay.rank.off);
    shf_nxt.rank_w = up_lay.rank.wid;
    shf_nxt.bank   = dam_pkg::BANK_W'(up_addr >> up_lay.bank.off);
    shf_nxt.bank_w = up_lay.bank.wid;
    shf_nxt.row    = up_lay.fixed ? fix_row :
                     dam_pkg::ROW_W'(up_addr >> up_lay.row.off);
    shf_nxt.row_w  = up_lay.row.wid;
    shf_nxt.lo     = dam_pkg::COL_W'(up_addr >> up_lay.lo.off);
    shf_nxt.lo_w   = up_lay.lo.wid;
    shf_nxt.hi     = dam_pkg::COL_W'(up_addr >> up_lay.hi.off);
    shf_nxt.hi_w   = up_lay.hi.wid;
    shf_nxt.lo_sh  = up_lay.lo_sh;
    shf_nxt.oor    = up_lay.known && ((up_addr >> up_lay.total) != '0);
  end

  assign up_ready = !v_r || dn_ready;

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  // Load the payload on a transfer
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      shf_r <= shf_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_shf   = shf_r;

endmodule

`default_nettype wire

FILE: sv/dam_pack.sv
`timescale 1ns / 1ps
`default_nettype none

module dam_pack (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  input  wire dam_pkg::shf_t               up_shf,
  output logic                             up_ready,
  input  wire logic                        dn_ready,
  output logic                             dn_valid,
  output logic [dam_pkg::CHAN_W-1:0]       chan_id,
  output logic [dam_pkg::RANK_W-1:0]       rank_id,
  output logic [dam_pkg::BANK_W-1:0]       bank_id,
  output logic [dam_pkg::ROW_W-1:0]        row_id,
  output logic [dam_pkg::COL_W-1:0]        col_id,
  output logic                             out_of_range
);

  logic                        v_r;
  logic [dam_pkg::CHAN_W-1:0]  chan_r, chan_nxt;
  logic [dam_pkg::RANK_W-1:0]  rank_r, rank_nxt;
  logic [dam_pkg::BANK_W-1:0]  bank_r, bank_nxt;
  logic [dam_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [dam_pkg::COL_W-1:0]   col_r, col_nxt;
  logic                        oor_r, oor_nxt;
  logic [dam_pkg::COL_W-1:0]   lo_m;
  logic [dam_pkg::COL_W-1:0]   hi_m;

  // Mask to field widths, merge the column halves, drop unknown modes
  always_comb begin
    lo_m     = up_shf.lo & dam_pkg::COL_W'(dam_pkg::low_mask(up_shf.lo_w));
    hi_m     = up_shf.hi & dam_pkg::COL_W'(dam_pkg::low_mask(up_shf.hi_w));
    chan_nxt = '0;
    rank_nxt = '0;
    bank_nxt = '0;
    row_nxt  = '0;
    col_nxt  = '0;
    oor_nxt  = 1'b0;
    if (up_shf.known) begin
      chan_nxt = up_shf.chan & dam_pkg::CHAN_W'(dam_pkg::low_mask(up_shf.chan_w));
      rank_nxt = up_shf.rank & dam_pkg::RANK_W'(dam_pkg::low_mask(up_shf.rank_w));
      bank_nxt = up_shf.bank & dam_pkg::BANK_W'(dam_pkg::low_mask(up_shf.bank_w));
      row_nxt  = up_shf.row & dam_pkg::low_mask(up_shf.row_w);
      col_nxt  = lo_m | (hi_m << up_shf.lo_sh);
      oor_nxt  = up_shf.oor;
    end
  end

  assign up_ready = !v_r || dn_ready;

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  // Load the result on a transfer
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      chan_r <= chan_nxt;
      rank_r <= rank_nxt;
      bank_r <= bank_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      oor_r  <= oor_nxt;
    end
  end

  assign dn_valid     = v_r;
  assign chan_id      = chan_r;
  assign rank_id      = rank_r;
  assign bank_id      = bank_r;
  assign row_id       = row_r;
  assign col_id       = col_r;
  assign out_of_range = oor_r;

endmodule

`default_nettype wire

FILE: sv/dram_address_mapper.sv
// DRAM address mapper.
// Input channel: in_valid/in_ready carry one physical byte address
// (in_phys_addr). Output channel: out_valid/out_ready carry the channel,
// rank, bank, row and column indices and an out-of-range flag.
// Configuration: cfg_wr_en writes cfg_wdata into the register selected
// by cfg_index (map mode, then the log2 widths); write only while idle.
// Three register stages: field placement from the widths, the per-field
// barrel shifts, then masking and column merge; out_valid rises once an
// accepted address sits in the last. Throughput is one address per cycle
// while out_ready stays high; each stage has its own valid bit and
// takes a new item whenever it is empty or its content moves on in
// the same cycle.
// When the receiver holds out_ready low the result holds in the output
// register, and the stages behind it keep filling until all three are
// full; only then does in_ready drop. Nothing is dropped or repeated.
// Reset (rst_n low at a clock edge) empties all stages and loads the
// configuration defaults: open-page mode with 2 rank, 2 bank, 13 row,
// 10 column, 3 column-size and 6 line bits, no channel bits.
`timescale 1ns / 1ps
`default_nettype none

module dram_address_mapper #(
  parameter int unsigned ADDR_WIDTH = dam_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [dam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dam_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [dam_pkg::PHYS_W-1:0]     in_phys_addr,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [dam_pkg::CHAN_W-1:0]          out_chan_id,
  output logic [dam_pkg::RANK_W-1:0]          out_rank_id,
  output logic [dam_pkg::BANK_W-1:0]          out_bank_id,
  output logic [dam_pkg::ROW_W-1:0]           out_row_id,
  output logic [dam_pkg::COL_W-1:0]           out_col_id,
  output logic                                out_out_of_range
);

  // Address bits that take part; the input field is never wider
  localparam int unsigned AddrW =
    (ADDR_WIDTH < dam_pkg::PHYS_W) ? ADDR_WIDTH : dam_pkg::PHYS_W;

  dam_pkg::cfg_t     cfg;
  logic              s1_valid;
  logic              s1_ready;
  logic [AddrW-1:0]  s1_addr;
  dam_pkg::lay_t     s1_lay;
  logic              s2_valid;
  logic              s2_ready;
  dam_pkg::shf_t     s2_shf;

  dam_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dam_plan #(
    .ADDR_W (AddrW)
  ) u_plan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_addr  (in_phys_addr),
    .up_ready (in_ready),
    .dn_ready (s1_ready),
    .dn_valid (s1_valid),
    .dn_addr  (s1_addr),
    .dn_lay   (s1_lay)
  );

  dam_shift #(
    .ADDR_W (AddrW)
  ) u_shift (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_addr  (s1_addr),
    .up_lay   (s1_lay),
    .up_ready (s1_ready),
    .dn_ready (s2_ready),
    .dn_valid (s2_valid),
    .dn_shf   (s2_shf)
  );

  dam_pack u_pack (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (s2_valid),
    .up_shf       (s2_shf),
    .up_ready     (s2_ready),
    .dn_ready     (out_ready),
    .dn_valid     (out_valid),
    .chan_id      (out_chan_id),
    .rank_id      (out_rank_id),
    .bank_id      (out_bank_id),
    .row_id       (out_row_id),
    .col_id       (out_col_id),
    .out_of_range (out_out_of_range)
  );

`ifndef SYNTHESIS
  // Items in flight change only by input and output transfers
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      (int'($countones({s1_valid, s2_valid, out_valid})) ==
       int'($countones($past({s1_valid, s2_valid, out_valid})))
       + int'($past(in_valid && in_ready))
       - int'($past(out_valid && out_ready))))
    else $error("pipeline lost or invented an item");

  // Input backpressure only when every stage is full and the output stalls
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid && s2_valid && out_valid && !out_ready))
    else $error("input stalled with room in the pipeline");

  // After reset the pipeline is empty
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> (!s1_valid && !s2_valid && !out_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

FILE: test/dram_address_mapper_tb.sv
`timescale 1ns / 1ps

module dram_address_mapper_tb;
  import dam_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 2000;
  // Three pipeline stages plus margin
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [2:0] MODE_LAST = 3'd7;

  localparam cfg_t RESET_CFG = '{map_mode: MODE_OPEN, chan_bits: 3'd0, rank_bits: 3'd2,
                                 bank_bits: 3'd2, row_bits: 5'd13, col_bits: 5'd10,
                                 col_size_bits: 3'd3, line_bits: 4'd6};
  localparam cfg_t WIDEST_CFG = '{map_mode: MODE_CHAN_COL, chan_bits: 3'd4, rank_bits: 3'd4,
                                  bank_bits: 3'd5, row_bits: 5'd20, col_bits: 5'd16,
                                  col_size_bits: 3'd6, line_bits: 4'd10};
  localparam cfg_t NARROWEST_CFG = '{map_mode: MODE_CLOSE, chan_bits: 3'd0, rank_bits: 3'd0,
                                     bank_bits: 3'd0, row_bits: 5'd0, col_bits: 5'd0,
                                     col_size_bits: 3'd0, line_bits: 4'd0};

  typedef struct packed {
    logic [CHAN_W-1:0] chan_id;
    logic [RANK_W-1:0] rank_id;
    logic [BANK_W-1:0] bank_id;
    logic [ROW_W-1:0]  row_id;
    logic [COL_W-1:0]  col_id;
    logic              out_of_range;
  } addr_fields_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PHYS_W-1:0]     in_phys_addr = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAN_W-1:0]     out_chan_id;
  logic [RANK_W-1:0]     out_rank_id;
  logic [BANK_W-1:0]     out_bank_id;
  logic [ROW_W-1:0]      out_row_id;
  logic [COL_W-1:0]      out_col_id;
  logic                  out_out_of_range;

  cfg_t         mapper_cfg = RESET_CFG;
  addr_fields_t expected_fields_q[$];
  int unsigned  mismatches = 0;
  int unsigned  burst_left = 0;
  int unsigned  rx_mode = 0;
  int unsigned  rx_left = 0;

  dram_address_mapper dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_phys_addr     (in_phys_addr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_chan_id      (out_chan_id),
    .out_rank_id      (out_rank_id),
    .out_bank_id      (out_bank_id),
    .out_row_id       (out_row_id),
    .out_col_id       (out_col_id),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // n bits of a starting at bit pos; anything past bit 63 reads as zero
  function automatic logic [63:0] bits_at(logic [63:0] a, int unsigned pos, int unsigned n);
    logic [63:0] s;
    logic [63:0] m;
    s = (pos >= 64) ? 64'd0 : (a >> pos);
    m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    return s & m;
  endfunction

  // Split one address into its DRAM coordinates under configuration c
  function automatic addr_fields_t map_address(logic [31:0] addr, cfg_t c);
    addr_fields_t r;
    logic [63:0]  a;
    logic [63:0]  chan, rank, bank, row, col, lo, hi;
    int unsigned  pos;
    int           lo_w, hi_w;
    logic         oor;
    r = '0;
    chan = '0; rank = '0; bank = '0; row = '0; col = '0; lo = '0; hi = '0;
    oor = 1'b0;
    pos = 0;
    // Drop the bytes within one bus-wide column
    a = 64'(addr) >> c.col_size_bits;
    lo_w = int'(c.line_bits) - int'(c.col_size_bits);
    if (lo_w < 0) lo_w = 0;
    hi_w = int'(c.col_bits) - lo_w;
    if (hi_w < 0) hi_w = 0;
    case (c.map_mode)
      MODE_CHAN_COL: begin
        chan = bits_at(a, pos, c.chan_bits); pos += c.chan_bits;
        col  = bits_at(a, pos, c.col_bits);  pos += c.col_bits;
        rank = bits_at(a, pos, c.rank_bits); pos += c.rank_bits;
        bank = bits_at(a, pos, c.bank_bits); pos += c.bank_bits;
        row  = bits_at(a, pos, c.row_bits);  pos += c.row_bits;
        oor  = (bits_at(a, pos, 64) != 0);
      end
      MODE_OPEN: begin
        lo   = bits_at(a, pos, lo_w);        pos += lo_w;
        chan = bits_at(a, pos, c.chan_bits); pos += c.chan_bits;
        hi   = bits_at(a, pos, hi_w);        pos += hi_w;
        bank = bits_at(a, pos, c.bank_bits); pos += c.bank_bits;
        rank = bits_at(a, pos, c.rank_bits); pos += c.rank_bits;
        row  = bits_at(a, pos, c.row_bits);  pos += c.row_bits;
        col  = (hi << lo_w) | lo;
        oor  = (bits_at(a, pos, 64) != 0);
      end
      MODE_SDRAM: begin
        lo   = bits_at(a, pos, lo_w);        pos += lo_w;
        chan = bits_at(a, pos, c.chan_bits); pos += c.chan_bits;
        hi   = bits_at(a, pos, hi_w);        pos += hi_w;
        bank = bits_at(a, pos, c.bank_bits); pos += c.bank_bits;
        row  = bits_at(a, pos, c.row_bits);  pos += c.row_bits;
        rank = bits_at(a, pos, c.rank_bits); pos += c.rank_bits;
        col  = (hi << lo_w) | lo;
        oor  = (bits_at(a, pos, 64) != 0);
      end
      MODE_CLOSE: begin
        lo   = bits_at(a, pos, lo_w);        pos += lo_w;
        chan = bits_at(a, pos, c.chan_bits); pos += c.chan_bits;
        bank = bits_at(a, pos, c.bank_bits); pos += c.bank_bits;
        rank = bits_at(a, pos, c.rank_bits); pos += c.rank_bits;
        hi   = bits_at(a, pos, hi_w);        pos += hi_w;
        row  = bits_at(a, pos, c.row_bits);  pos += c.row_bits;
        col  = (hi << lo_w) | lo;
        oor  = (bits_at(a, pos, 64) != 0);
      end
      MODE_FIXED: begin
        // Fixed chipset layout works on the raw address; row bit 11 stays zero
        col  = 64'(addr[12:3]);
        bank = 64'(addr[14:13]);
        row  = 64'({addr[27], addr[15], 1'b0, addr[26:16]});
        rank = 64'(addr[29:28]);
        oor  = |addr[31:30];
      end
      default: ;
    endcase
    r.chan_id      = chan[CHAN_W-1:0];
    r.rank_id      = rank[RANK_W-1:0];
    r.bank_id      = bank[BANK_W-1:0];
    r.row_id       = row[ROW_W-1:0];
    r.col_id       = col[COL_W-1:0];
    r.out_of_range = oor;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Write one register and track it in the local copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MAP_MODE:  mapper_cfg.map_mode      = val[2:0];
      REG_CHAN_BITS: mapper_cfg.chan_bits     = val[2:0];
      REG_RANK_BITS: mapper_cfg.rank_bits     = val[2:0];
      REG_BANK_BITS: mapper_cfg.bank_bits     = val[2:0];
      REG_ROW_BITS:  mapper_cfg.row_bits      = val[4:0];
      REG_COL_BITS:  mapper_cfg.col_bits      = val[4:0];
      REG_CSZ_BITS:  mapper_cfg.col_size_bits = val[2:0];
      REG_LINE_BITS: mapper_cfg.line_bits     = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_config(cfg_t c);
    write_reg(REG_MAP_MODE,  CFG_DATA_W'(c.map_mode));
    write_reg(REG_CHAN_BITS, CFG_DATA_W'(c.chan_bits));
    write_reg(REG_RANK_BITS, CFG_DATA_W'(c.rank_bits));
    write_reg(REG_BANK_BITS, CFG_DATA_W'(c.bank_bits));
    write_reg(REG_ROW_BITS,  CFG_DATA_W'(c.row_bits));
    write_reg(REG_COL_BITS,  CFG_DATA_W'(c.col_bits));
    write_reg(REG_CSZ_BITS,  CFG_DATA_W'(c.col_size_bits));
    write_reg(REG_LINE_BITS, CFG_DATA_W'(c.line_bits));
  endtask

  // Present one address in the current burst; open a gap when the burst runs out
  task automatic send_addr(logic [31:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_phys_addr <= addr;
    do @(posedge clk); while (!in_ready);
    expected_fields_q.push_back(map_address(addr, mapper_cfg));
    burst_left--;
  endtask

  // Drop valid after the last transfer, then wait out every expected result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_fields_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0, 1:    v = v & 32'((64'd1 << $urandom_range(0, 32)) - 64'd1);
      2:       v = 32'hFFFF_FFFF;
      3:       v = 32'd1 << $urandom_range(0, 31);
      4:       v = v >> $urandom_range(0, 31);
      default: ;
    endcase
    return v;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.map_mode      = ($urandom_range(0, 7) == 0) ?
                      3'($urandom_range(MODE_CLOSE + 1, MODE_LAST)) :
                      3'($urandom_range(MODE_CHAN_COL, MODE_CLOSE));
    c.chan_bits     = 3'($urandom_range(0, 4));
    c.rank_bits     = 3'($urandom_range(0, 4));
    c.bank_bits     = 3'($urandom_range(0, 5));
    c.row_bits      = 5'($urandom_range(0, 20));
    c.col_bits      = 5'($urandom_range(0, 16));
    c.col_size_bits = 3'($urandom_range(0, 6));
    c.line_bits     = 4'($urandom_range(0, 10));
    return c;
  endfunction

  // Default open-page layout straight out of reset
  task automatic test_reset_defaults();
    send_addr(32'h0000_0000);
    send_addr(32'hFFFF_FFFF);
    send_addr(32'h0123_4567);
    drain_results();
  endtask

  // Every scheme, unknown ones too, with all-ones and alternating addresses
  task automatic test_each_mode();
    write_reg(REG_CHAN_BITS, CFG_DATA_W'(2));
    for (int m = 0; m <= MODE_LAST; m++) begin
      write_reg(REG_MAP_MODE, CFG_DATA_W'(m));
      send_addr(32'hFFFF_FFFF);
      send_addr(m[0] ? 32'h5555_5555 : 32'hAAAA_AAAA);
      drain_results();
    end
  endtask

  // Column low width below zero, then column high width below zero
  task automatic test_column_widths();
    write_reg(REG_MAP_MODE, CFG_DATA_W'(MODE_OPEN));
    write_reg(REG_CSZ_BITS, CFG_DATA_W'(6));
    write_reg(REG_LINE_BITS, CFG_DATA_W'(0));
    send_addr(32'hFFFF_FFFF);
    send_addr(32'h8765_4321);
    drain_results();
    write_reg(REG_MAP_MODE, CFG_DATA_W'(MODE_CLOSE));
    write_reg(REG_CSZ_BITS, CFG_DATA_W'(0));
    write_reg(REG_LINE_BITS, CFG_DATA_W'(10));
    write_reg(REG_COL_BITS, CFG_DATA_W'(2));
    send_addr(32'hFFFF_FFFF);
    send_addr(32'h0000_07FF);
    drain_results();
  endtask

  // Random settings per phase, widest and narrowest first
  task automatic test_random_configs();
    int unsigned phase;
    int unsigned sent;
    int unsigned n;
    cfg_t        c;
    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase < 4) begin
        c = phase[0] ? NARROWEST_CFG : WIDEST_CFG;
        c.map_mode = 3'($urandom_range(MODE_CHAN_COL, MODE_CLOSE));
      end else begin
        c = random_config();
      end
      write_config(c);
      n = $urandom_range(40, 160);
      for (int unsigned i = 0; i < n; i++) begin
        // Hold the sender until the pipeline is empty now and then
        if (i == n / 2 && phase % 4 == 2) drain_results();
        send_addr(pick_addr());
        sent++;
      end
      drain_results();
      phase++;
    end
  endtask

  // Receiver: switch between random stall patterns, from always ready to rarely ready
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    addr_fields_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_fields_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_row_id, 0);
      end else begin
        want = expected_fields_q.pop_front();
        if (out_chan_id != want.chan_id)
          report_mismatch("chan_id", out_chan_id, want.chan_id);
        if (out_rank_id != want.rank_id)
          report_mismatch("rank_id", out_rank_id, want.rank_id);
        if (out_bank_id != want.bank_id)
          report_mismatch("bank_id", out_bank_id, want.bank_id);
        if (out_row_id != want.row_id)
          report_mismatch("row_id", out_row_id, want.row_id);
        if (out_col_id != want.col_id)
          report_mismatch("col_id", out_col_id, want.col_id);
        if (out_out_of_range != want.out_of_range)
          report_mismatch("out_of_range", out_out_of_range, want.out_of_range);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_each_mode();
    test_column_widths();
    test_random_configs();
    drain_results();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/dam_pkg.sv
sv/dam_cfg.sv
sv/dam_plan.sv
sv/dam_shift.sv
sv/dam_pack.sv
sv/dram_address_mapper.sv
test/dram_address_mapper_tb.sv
